/* hw/rtl/pplsv_pkg.sv */
// shared types, codes and constants of the ping/pong link supervisor
package pplsv_pkg;

    // request kinds carried on s_tuser
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_PONG  = 3'd1;
    localparam logic [2:0] REQ_PING  = 3'd2;
    localparam logic [2:0] REQ_RANGE = 3'd3;
    localparam logic [2:0] REQ_FAIL  = 3'd4;

    // event kinds carried on m_tuser
    localparam logic [2:0] EV_HELLO   = 3'd0;
    localparam logic [2:0] EV_PING    = 3'd1;
    localparam logic [2:0] EV_PONG    = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_DONE    = 3'd4;
    localparam logic [2:0] EV_REJECT  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_NODE_ID   = 3'd0;
    localparam logic [2:0] CFG_BCAST_ID  = 3'd1;
    localparam logic [2:0] CFG_AUTO_PING = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [2:0] CFG_BEACON    = 3'd4;
    localparam logic [2:0] CFG_MAX_HOPS  = 3'd5;

    // configuration reset values
    localparam logic [31:0] RST_NODE_ID   = 32'd0;
    localparam logic [31:0] RST_BCAST_ID  = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_AUTO_PING = 32'd0;
    localparam logic [31:0] RST_TIMEOUT   = 32'd3000;
    localparam logic [31:0] RST_BEACON    = 32'd0;
    localparam logic [7:0]  RST_MAX_HOPS  = 8'd1;

    // multi-hop floors
    localparam logic [31:0] MIN_AUTO_MULTIHOP    = 32'd3200;
    localparam logic [31:0] MIN_TIMEOUT_MULTIHOP = 32'd4500;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one result item
    typedef struct packed {
        logic [2:0]  ev;
        logic [31:0] seq;
        logic [31:0] rtt;
        logic [15:0] sent;
    } res_t;

    // the results of one input item: one or two
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } entry_t;

    function automatic res_t mk_res(logic [2:0] ev, logic [31:0] seq, logic [31:0] rtt,
                                    logic [15:0] sent);
        res_t r;
        r.ev   = ev;
        r.seq  = seq;
        r.rtt  = rtt;
        r.sent = sent;
        return r;
    endfunction

endpackage

/* hw/rtl/pplsv_front.sv */
// front end: configuration, link state and event generation per input item
module pplsv_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [2:0]          req_type,
    input  logic [31:0]         dest_id,
    input  logic [31:0]         pong_timestamp,
    input  logic [15:0]         range_count,
    output logic                push,
    output pplsv_pkg::entry_t   entry
);

    logic [31:0] node_id_reg, bcast_id_reg, auto_ping_reg, timeout_reg, beacon_reg;
    logic [7:0]  max_hops_reg;

    logic [31:0] now_reg, now_next;
    logic        waiting_reg, waiting_next;
    logic [31:0] ping_number_reg, ping_number_next;
    logic [31:0] ping_time_reg, ping_time_next;
    logic [31:0] hello_number_reg, hello_number_next;
    logic [31:0] hello_time_reg, hello_time_next;
    logic [31:0] auto_time_reg, auto_time_next;
    logic        range_active_reg, range_active_next;
    logic [15:0] range_total_reg, range_total_next;
    logic [15:0] range_sent_reg, range_sent_next;

    logic        acc, multi, hello_due, auto_due, to_due, pong_ok, adv_ping, has;
    logic [31:0] now_inc, eff_auto, eff_to, ping_inc, adv_time;
    logic [15:0] sent_inc;
    pplsv_pkg::res_t res0, res1;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg   <= pplsv_pkg::RST_NODE_ID;
            bcast_id_reg  <= pplsv_pkg::RST_BCAST_ID;
            auto_ping_reg <= pplsv_pkg::RST_AUTO_PING;
            timeout_reg   <= pplsv_pkg::RST_TIMEOUT;
            beacon_reg    <= pplsv_pkg::RST_BEACON;
            max_hops_reg  <= pplsv_pkg::RST_MAX_HOPS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pplsv_pkg::CFG_NODE_ID:   node_id_reg   <= cfg_data;
                pplsv_pkg::CFG_BCAST_ID:  bcast_id_reg  <= cfg_data;
                pplsv_pkg::CFG_AUTO_PING: auto_ping_reg <= cfg_data;
                pplsv_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                pplsv_pkg::CFG_BEACON:    beacon_reg    <= cfg_data;
                pplsv_pkg::CFG_MAX_HOPS:  max_hops_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // shared terms: effective periods and due checks
    always_comb begin
        acc       = in_valid && in_ready;
        now_inc   = now_reg + 32'd1;
        multi     = max_hops_reg > 8'd1;
        eff_auto  = (multi && auto_ping_reg != 32'd0
                     && auto_ping_reg < pplsv_pkg::MIN_AUTO_MULTIHOP)
                    ? pplsv_pkg::MIN_AUTO_MULTIHOP : auto_ping_reg;
        eff_to    = (multi && timeout_reg < pplsv_pkg::MIN_TIMEOUT_MULTIHOP)
                    ? pplsv_pkg::MIN_TIMEOUT_MULTIHOP : timeout_reg;
        sent_inc  = (range_sent_reg == 16'hFFFF) ? range_sent_reg : range_sent_reg + 16'd1;
        ping_inc  = ping_number_reg + 32'd1;
        adv_ping  = range_active_reg && (range_sent_reg < range_total_reg);
        hello_due = (beacon_reg != 32'd0) && ((now_inc - hello_time_reg) >= beacon_reg);
        auto_due  = (eff_auto != 32'd0) && !range_active_reg
                    && ((now_inc - auto_time_reg) >= eff_auto);
        to_due    = (now_inc - ping_time_reg) > eff_to;
        pong_ok   = waiting_reg && (dest_id == node_id_reg || dest_id == bcast_id_reg);
        adv_time  = (req_type == pplsv_pkg::REQ_TICK) ? now_inc : now_reg;
    end

    // next state and results of the current item
    always_comb begin
        now_next          = now_reg;
        waiting_next      = waiting_reg;
        ping_number_next  = ping_number_reg;
        ping_time_next    = ping_time_reg;
        hello_number_next = hello_number_reg;
        hello_time_next   = hello_time_reg;
        auto_time_next    = auto_time_reg;
        range_active_next = range_active_reg;
        range_total_next  = range_total_reg;
        range_sent_next   = range_sent_reg;
        res0              = '0;
        res1              = '0;
        has               = 1'b0;
        entry.two         = 1'b0;
        unique case (req_type)
            pplsv_pkg::REQ_TICK: begin
                now_next = now_inc;
                if (waiting_reg) begin
                    if (to_due) begin
                        waiting_next = 1'b0;
                        has          = 1'b1;
                        res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_TIMEOUT, ping_number_reg,
                                                 32'd0, range_sent_reg);
                    end
                end else begin
                    if (hello_due) begin
                        hello_time_next   = now_inc;
                        hello_number_next = hello_number_reg + 32'd1;
                        has               = 1'b1;
                        res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_HELLO,
                                                 hello_number_reg + 32'd1, 32'd0,
                                                 range_sent_reg);
                    end
                    if (auto_due) begin
                        auto_time_next   = now_inc;
                        ping_number_next = ping_inc;
                        ping_time_next   = now_inc;
                        waiting_next     = 1'b1;
                        if (hello_due) begin
                            entry.two = 1'b1;
                            res1 = pplsv_pkg::mk_res(pplsv_pkg::EV_PING, ping_inc, 32'd0,
                                                     range_sent_reg);
                        end else begin
                            has  = 1'b1;
                            res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_PING, ping_inc, 32'd0,
                                                     range_sent_reg);
                        end
                    end
                end
            end
            pplsv_pkg::REQ_PONG: begin
                has = 1'b1;
                if (pong_ok) begin
                    waiting_next = 1'b0;
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_PONG, ping_number_reg,
                                             now_reg - pong_timestamp, range_sent_reg);
                end else begin
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_REJECT, 32'd0, 32'd0,
                                             range_sent_reg);
                end
            end
            pplsv_pkg::REQ_PING: begin
                has = 1'b1;
                if (waiting_reg) begin
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_REJECT, 32'd0, 32'd0,
                                             range_sent_reg);
                end else begin
                    ping_number_next = ping_inc;
                    ping_time_next   = now_reg;
                    waiting_next     = 1'b1;
                    range_sent_next  = range_active_reg ? sent_inc : range_sent_reg;
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_PING, ping_inc, 32'd0,
                                             range_active_reg ? sent_inc : range_sent_reg);
                end
            end
            pplsv_pkg::REQ_RANGE: begin
                has = 1'b1;
                if (range_active_reg) begin
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_REJECT, 32'd0, 32'd0,
                                             range_sent_reg);
                end else begin
                    range_active_next = 1'b1;
                    range_total_next  = range_count;
                    range_sent_next   = 16'd1;
                    ping_number_next  = ping_inc;
                    ping_time_next    = now_reg;
                    waiting_next      = 1'b1;
                    res0 = pplsv_pkg::mk_res(pplsv_pkg::EV_PING, ping_inc, 32'd0, 16'd1);
                end
            end
            pplsv_pkg::REQ_FAIL: begin
                waiting_next = 1'b0;
            end
            default: ;
        endcase

        // range test step after a pong or timeout ends a wait
        if (((req_type == pplsv_pkg::REQ_TICK && waiting_reg && to_due)
             || (req_type == pplsv_pkg::REQ_PONG && pong_ok)) && range_active_reg) begin
            entry.two = 1'b1;
            if (adv_ping) begin
                ping_number_next = ping_inc;
                ping_time_next   = adv_time;
                waiting_next     = 1'b1;
                range_sent_next  = sent_inc;
                res1 = pplsv_pkg::mk_res(pplsv_pkg::EV_PING, ping_inc, 32'd0, sent_inc);
            end else begin
                range_active_next = 1'b0;
                res1 = pplsv_pkg::mk_res(pplsv_pkg::EV_DONE, ping_number_reg, 32'd0,
                                         range_sent_reg);
            end
        end

        entry.r0 = res0;
        entry.r1 = res1;
        push     = acc && has;
    end

    // link state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg          <= '0;
            waiting_reg      <= 1'b0;
            ping_number_reg  <= '0;
            ping_time_reg    <= '0;
            hello_number_reg <= '0;
            hello_time_reg   <= '0;
            auto_time_reg    <= '0;
            range_active_reg <= 1'b0;
            range_total_reg  <= '0;
            range_sent_reg   <= '0;
        end else if (acc) begin
            now_reg          <= now_next;
            waiting_reg      <= waiting_next;
            ping_number_reg  <= ping_number_next;
            ping_time_reg    <= ping_time_next;
            hello_number_reg <= hello_number_next;
            hello_time_reg   <= hello_time_next;
            auto_time_reg    <= auto_time_next;
            range_active_reg <= range_active_next;
            range_total_reg  <= range_total_next;
            range_sent_reg   <= range_sent_next;
        end
    end

    // a new wait always comes with a ping sent event
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(waiting_reg) |-> $past(push && (entry.r0.ev == pplsv_pkg::EV_PING
                                              || entry.r1.ev == pplsv_pkg::EV_PING)))
        else $error("wait started without a ping sent event");

    // ping numbers only step by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ping_number_reg != $past(ping_number_reg))
            |-> (ping_number_reg == $past(ping_number_reg) + 32'd1))
        else $error("ping number jumped");

endmodule

/* hw/rtl/pplsv_queue.sv */
// short queue of per-item result groups between front and back
module pplsv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pplsv_pkg::entry_t   wr_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output pplsv_pkg::entry_t   head
);

    pplsv_pkg::entry_t            slots_reg [pplsv_pkg::QDEPTH];
    logic [pplsv_pkg::QAW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [pplsv_pkg::QAW:0]      count_reg, count_next;

    // status and head read
    always_comb begin
        full  = (count_reg == (pplsv_pkg::QAW+1)'(pplsv_pkg::QDEPTH));
        empty = (count_reg == '0);
        head  = slots_reg[rd_ptr_reg];
        count_next = count_reg + (pplsv_pkg::QAW+1)'(push) - (pplsv_pkg::QAW+1)'(pop);
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (pplsv_pkg::QAW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (pplsv_pkg::QAW)'(1);
            end
            count_reg <= count_next;
        end
    end

    // no overflow and no underflow
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(full && push) && !(empty && pop))
        else $error("result queue overflow or underflow");

endmodule

/* hw/rtl/pplsv_back.sv */
// back end: splits result groups into single transactions on the output register
module pplsv_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                empty,
    input  pplsv_pkg::entry_t   head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);

    logic            valid_reg, valid_next;
    logic            sel_reg, sel_next;
    pplsv_pkg::res_t res_reg, res_next;
    logic            last_reg, last_next;
    logic            load;

    // load the next result whenever the output register frees up
    always_comb begin
        load       = !empty && (!valid_reg || m_tready);
        valid_next = valid_reg;
        sel_next   = sel_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            res_next   = sel_reg ? head.r1 : head.r0;
            last_next  = sel_reg || !head.two;
            if (sel_reg || !head.two) begin
                pop      = 1'b1;
                sel_next = 1'b0;
            end else begin
                sel_next = 1'b1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    // output port drive
    always_comb begin
        m_tvalid = valid_reg;
        m_tdata  = {res_reg.sent, res_reg.rtt, res_reg.seq};
        m_tuser  = res_reg.ev;
        m_tlast  = last_reg;
    end

    // a first result on show means its partner is next from the queue head
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> (sel_reg && !empty))
        else $error("second result of a group lost");

endmodule

/* hw/rtl/ping_pong_link_supervisor.sv */
// top level of the ping/pong link supervisor
// Takes one request per cycle while s_tready is high (tick, pong, ping command,
// range test, send failure) and answers with zero, one or two event transactions,
// the final one of each request marked by m_tlast. A request is handled in the
// cycle it is taken; its events pass through the queue into the output register
// and leave one per cycle while m_tready is high, so the output register sets the
// sustained rate: one request per cycle while each gives at most one event, and a
// request with two events holds it for both. A four-group queue between the
// request logic and the output register absorbs stalls on the event side;
// s_tready falls only once four groups are waiting. Configuration writes are
// always taken and belong in idle periods. No clearing pass after reset.
module ping_pong_link_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // dest_id[31:0], pong_timestamp[63:32], range_count[79:64]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    // event channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // seq[31:0], rtt_ms[63:32], sent_count[79:64]
    output logic [2:0]  m_tuser,   // event_res[2:0]
    output logic        m_tlast
);

    logic              push, full, pop, empty;
    pplsv_pkg::entry_t wr_entry, head;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;

    pplsv_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .req_type       (s_tuser),
        .dest_id        (s_tdata[31:0]),
        .pong_timestamp (s_tdata[63:32]),
        .range_count    (s_tdata[79:64]),
        .push           (push),
        .entry          (wr_entry)
    );

    pplsv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    pplsv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
